/* rtl/core/rtq_pkg.sv */
// ----------------------------------------------------------------------------
// rtq_pkg: shared definitions for the repeating timer event queue
// Request and status codes, default sizes and the cell command word.
// ----------------------------------------------------------------------------
package rtq_pkg;

   // Default sizes handed to the top level's parameters.
   localparam int DEF_SLOTS      = 16;
   localparam int DEF_TIME_WIDTH = 32;

   // Most firings that one tick may report.
   localparam int MAX_RESULTS = 16;

   // Request codes.
   localparam logic [1:0] REQ_ARM    = 2'd0;
   localparam logic [1:0] REQ_DISARM = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;

   // Status codes.
   localparam logic [1:0] ST_ACK      = 2'd0;
   localparam logic [1:0] ST_FIRED    = 2'd1;
   localparam logic [1:0] ST_NONE_DUE = 2'd2;
   localparam logic [1:0] ST_INACTIVE = 2'd3;

   // Command word broadcast from the controller to every cell.
   typedef struct packed {
      logic arm;      // load the selected cell
      logic disarm;   // clear the selected cell
      logic capture;  // every cell latches its due flag against the current time
      logic fire;     // the selected cell fires and retires or re-arms
      logic stamp;    // the selected cell becomes the most recently armed
   } cell_cmd_type;

endpackage

/* rtl/core/rtq_cell.sv */
// ----------------------------------------------------------------------------
// rtq_cell: one timer slot of the chain
// Holds one timer, its recency rank and its due flag, and passes on the
// better of its own candidate and the one that arrives from its neighbour.
// ----------------------------------------------------------------------------
module rtq_cell
   import rtq_pkg::*;
#(
   parameter int SLOTS      = DEF_SLOTS,
   parameter int TIME_WIDTH = DEF_TIME_WIDTH,
   parameter int INDEX      = 0,
   localparam int SW        = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_cmd_type          cmd,
   input  logic [SW-1:0]         sel_idx,
   input  logic [TIME_WIDTH-1:0] wr_deadline,
   input  logic [TIME_WIDTH-1:0] wr_period,
   input  logic [15:0]           wr_repeats,
   input  logic [TIME_WIDTH-1:0] now,
   input  logic [SW-1:0]         stamp_age,
   input  logic                  tok_valid_in,
   input  logic [SW-1:0]         tok_idx_in,
   input  logic [TIME_WIDTH-1:0] tok_deadline_in,
   input  logic [SW-1:0]         tok_age_in,
   input  logic                  tok_final_in,
   output logic                  tok_valid_out,
   output logic [SW-1:0]         tok_idx_out,
   output logic [TIME_WIDTH-1:0] tok_deadline_out,
   output logic [SW-1:0]         tok_age_out,
   output logic                  tok_final_out,
   output logic                  armed,
   output logic [SW-1:0]         age
);

   logic                  armed_ff, armed_in;
   logic                  due_ff, due_in;
   logic [SW-1:0]         age_ff, age_in;
   logic [TIME_WIDTH-1:0] deadline_ff, deadline_in;
   logic [TIME_WIDTH-1:0] period_ff, period_in;
   logic [15:0]           repeats_ff, repeats_in;
   logic                  tvalid_ff;
   logic [SW-1:0]         tidx_ff;
   logic [TIME_WIDTH-1:0] tdeadline_ff;
   logic [SW-1:0]         tage_ff;
   logic                  tfinal_ff;
   logic                  hit;
   logic                  own_wins;

   assign hit = (sel_idx == SW'(INDEX));

   // Slot state update for the broadcast command.
   always_comb begin
      armed_in    = armed_ff;
      due_in      = due_ff;
      deadline_in = deadline_ff;
      period_in   = period_ff;
      repeats_in  = repeats_ff;
      age_in      = age_ff;
      if (cmd.capture) begin
         due_in = armed_ff && (deadline_ff <= now);
      end
      if (hit && cmd.arm) begin
         armed_in    = 1'b1;
         deadline_in = wr_deadline;
         period_in   = wr_period;
         repeats_in  = wr_repeats;
      end
      if (hit && cmd.disarm) begin
         armed_in = 1'b0;
      end
      if (hit && cmd.fire) begin
         due_in = 1'b0;
         if (repeats_ff == 16'd1) begin
            armed_in = 1'b0;
         end else begin
            deadline_in = deadline_ff + period_ff;
            if (repeats_ff > 16'd1) begin
               repeats_in = repeats_ff - 16'd1;
            end
         end
      end
      // Ranks stay a permutation: the stamped cell goes to rank zero and every
      // cell that was more recent than it moves one place back.
      if (cmd.stamp) begin
         if (hit) begin
            age_in = '0;
         end else if (age_ff < stamp_age) begin
            age_in = age_ff + 1'b1;
         end
      end
   end

   // Earlier deadline wins; on a tie the more recently armed cell wins.
   assign own_wins = due_ff &&
                     (!tok_valid_in || (deadline_ff < tok_deadline_in) ||
                      ((deadline_ff == tok_deadline_in) && (age_ff < tok_age_in)));

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff  <= 1'b0;
         due_ff    <= 1'b0;
         age_ff    <= SW'(INDEX);
         tvalid_ff <= 1'b0;
      end else begin
         armed_ff  <= armed_in;
         due_ff    <= due_in;
         age_ff    <= age_in;
         tvalid_ff <= own_wins || tok_valid_in;
      end
   end

   // Timer values and the candidate carry no reset.
   always_ff @(posedge clock) begin
      deadline_ff <= deadline_in;
      period_ff   <= period_in;
      repeats_ff  <= repeats_in;
      if (own_wins) begin
         tidx_ff      <= SW'(INDEX);
         tdeadline_ff <= deadline_ff;
         tage_ff      <= age_ff;
         tfinal_ff    <= (repeats_ff == 16'd1);
      end else begin
         tidx_ff      <= tok_idx_in;
         tdeadline_ff <= tok_deadline_in;
         tage_ff      <= tok_age_in;
         tfinal_ff    <= tok_final_in;
      end
   end

   assign tok_valid_out    = tvalid_ff;
   assign tok_idx_out      = tidx_ff;
   assign tok_deadline_out = tdeadline_ff;
   assign tok_age_out      = tage_ff;
   assign tok_final_out    = tfinal_ff;
   assign armed            = armed_ff;
   assign age              = age_ff;

endmodule

/* rtl/core/repeating_timer_event_queue_top.sv */
// ----------------------------------------------------------------------------
// repeating_timer_event_queue_top: sorted queue of repeating timers
// Arm, disarm and tick commands over a chain of timer cells.
// ----------------------------------------------------------------------------
// Arm, disarm and unknown commands give one result word in the cycle after
// start and leave busy low. A tick keeps busy high while it works: for each
// firing the best due timer travels once down the chain of cells, one cell
// per cycle, and an empty pass that finds no due timer ends the tick. A tick
// that reaches MAX_RESULTS firings skips the empty pass and ends in the
// flush state instead. Results are strobed by rsp_valid for one cycle and
// must be taken at once; the receiver cannot stall the block. Each firing
// word is shown when the next pass ends, or from the flush state for the
// firing that reaches MAX_RESULTS, so that the final word of a tick carries
// rsp_last.
module repeating_timer_event_queue_top
   import rtq_pkg::*;
#(
   parameter int SLOTS      = DEF_SLOTS,
   parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_type,
   input  logic [3:0]            req_slot,
   input  logic [TIME_WIDTH-1:0] req_deadline,
   input  logic [TIME_WIDTH-1:0] req_period,
   input  logic [15:0]           req_repeat_count,
   input  logic [TIME_WIDTH-1:0] req_now,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [3:0]            rsp_fired_slot,
   output logic [TIME_WIDTH-1:0] rsp_fire_time,
   output logic                  rsp_will_repeat,
   output logic [4:0]            rsp_active_count,
   output logic                  rsp_last
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int KW = $clog2(MAX_RESULTS + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_PICK  = 2'd2;
   localparam logic [1:0] S_FLUSH = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [CW-1:0]         scan_ff, scan_in;
   logic [KW-1:0]         fired_ff, fired_in;
   logic [CW-1:0]         live_ff, live_in;

   logic                  pend_valid_ff, pend_valid_in;
   logic [SW-1:0]         pend_slot_ff, pend_slot_in;
   logic [TIME_WIDTH-1:0] pend_time_ff, pend_time_in;
   logic                  pend_rep_ff, pend_rep_in;
   logic [CW-1:0]         pend_live_ff, pend_live_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [3:0]            rsp_slot_ff, rsp_slot_in;
   logic [TIME_WIDTH-1:0] rsp_time_ff, rsp_time_in;
   logic                  rsp_rep_ff, rsp_rep_in;
   logic [4:0]            rsp_count_ff, rsp_count_in;
   logic                  rsp_last_ff, rsp_last_in;

   cell_cmd_type          cmd;
   logic                  accept;
   logic                  in_range;
   logic [SW-1:0]         slot_idx;
   logic [SW-1:0]         sel_idx;
   logic [SW-1:0]         stamp_age;

   // Chain of candidates: entry i feeds cell i, entry SLOTS is the chain end.
   logic                  tok_valid    [SLOTS+1];
   logic [SW-1:0]         tok_idx      [SLOTS+1];
   logic [TIME_WIDTH-1:0] tok_deadline [SLOTS+1];
   logic [SW-1:0]         tok_age      [SLOTS+1];
   logic                  tok_final    [SLOTS+1];
   logic [SLOTS-1:0]      armed_vec;
   logic [SW-1:0]         age_vec      [SLOTS];

   assign tok_valid[0]    = 1'b0;
   assign tok_idx[0]      = '0;
   assign tok_deadline[0] = '0;
   assign tok_age[0]      = '0;
   assign tok_final[0]    = 1'b0;

   // Row of timer cells.
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      rtq_cell #(
         .SLOTS      (SLOTS),
         .TIME_WIDTH (TIME_WIDTH),
         .INDEX      (i)
      ) u_cell (
         .clock            (clock),
         .reset            (reset),
         .cmd              (cmd),
         .sel_idx          (sel_idx),
         .wr_deadline      (req_deadline),
         .wr_period        (req_period),
         .wr_repeats       (req_repeat_count),
         .now              (req_now),
         .stamp_age        (stamp_age),
         .tok_valid_in     (tok_valid[i]),
         .tok_idx_in       (tok_idx[i]),
         .tok_deadline_in  (tok_deadline[i]),
         .tok_age_in       (tok_age[i]),
         .tok_final_in     (tok_final[i]),
         .tok_valid_out    (tok_valid[i+1]),
         .tok_idx_out      (tok_idx[i+1]),
         .tok_deadline_out (tok_deadline[i+1]),
         .tok_age_out      (tok_age[i+1]),
         .tok_final_out    (tok_final[i+1]),
         .armed            (armed_vec[i]),
         .age              (age_vec[i])
      );
   end

   // Command decode.
   assign accept   = start && !busy;
   assign in_range = ({1'b0, req_slot} < 5'(SLOTS)) || (SLOTS > 16);
   assign slot_idx = SW'(req_slot);

   always_comb begin
      cmd.arm     = accept && (req_type == REQ_ARM) && in_range;
      cmd.disarm  = accept && (req_type == REQ_DISARM) && in_range;
      cmd.capture = accept && (req_type == REQ_TICK);
      cmd.fire    = (state_ff == S_PICK) && tok_valid[SLOTS];
      cmd.stamp   = cmd.arm || (cmd.fire && !tok_final[SLOTS]);
      sel_idx     = cmd.fire ? tok_idx[SLOTS] : slot_idx;
      stamp_age   = cmd.fire ? tok_age[SLOTS] : age_vec[slot_idx];
   end

   // Armed timer count.
   always_comb begin
      live_in = live_ff;
      if (cmd.arm && !armed_vec[slot_idx]) begin
         live_in = live_ff + 1'b1;
      end else if (cmd.disarm && armed_vec[slot_idx]) begin
         live_in = live_ff - 1'b1;
      end else if (cmd.fire && tok_final[SLOTS]) begin
         live_in = live_ff - 1'b1;
      end
   end

   // Sequencer and result word.
   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      fired_in      = fired_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_time_in  = pend_time_ff;
      pend_rep_in   = pend_rep_ff;
      pend_live_in  = pend_live_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_ACK;
      rsp_slot_in   = 4'd0;
      rsp_time_in   = '0;
      rsp_rep_in    = 1'b0;
      rsp_count_in  = 5'(live_in);
      rsp_last_in   = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_type == REQ_TICK) begin
                  state_in      = S_SCAN;
                  scan_in       = '0;
                  fired_in      = '0;
                  pend_valid_in = 1'b0;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_slot_in  = req_slot;
                  if (((req_type == REQ_ARM) || (req_type == REQ_DISARM)) && !in_range) begin
                     rsp_status_in = ST_INACTIVE;
                  end else if ((req_type == REQ_DISARM) && !armed_vec[slot_idx]) begin
                     rsp_status_in = ST_INACTIVE;
                  end
               end
            end
         end
         S_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (scan_ff == CW'(SLOTS - 1)) begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            // A firing is held back one pass so the last word can be marked.
            if (tok_valid[SLOTS]) begin
               if (pend_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_FIRED;
                  rsp_slot_in   = 4'(pend_slot_ff);
                  rsp_time_in   = pend_time_ff;
                  rsp_rep_in    = pend_rep_ff;
                  rsp_count_in  = 5'(pend_live_ff);
                  rsp_last_in   = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_slot_in  = tok_idx[SLOTS];
               pend_time_in  = tok_deadline[SLOTS];
               pend_rep_in   = !tok_final[SLOTS];
               pend_live_in  = live_in;
               fired_in      = fired_ff + 1'b1;
               scan_in       = '0;
               if (fired_ff == KW'(MAX_RESULTS - 1)) begin
                  state_in = S_FLUSH;
               end else begin
                  state_in = S_SCAN;
               end
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (pend_valid_ff) begin
                  rsp_status_in = ST_FIRED;
                  rsp_slot_in   = 4'(pend_slot_ff);
                  rsp_time_in   = pend_time_ff;
                  rsp_rep_in    = pend_rep_ff;
                  rsp_count_in  = 5'(pend_live_ff);
               end else begin
                  rsp_status_in = ST_NONE_DUE;
               end
            end
         end
         S_FLUSH: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_FIRED;
            rsp_slot_in   = 4'(pend_slot_ff);
            rsp_time_in   = pend_time_ff;
            rsp_rep_in    = pend_rep_ff;
            rsp_count_in  = 5'(pend_live_ff);
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         scan_ff       <= '0;
         fired_ff      <= '0;
         live_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         fired_ff      <= fired_in;
         live_ff       <= live_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_slot_ff  <= pend_slot_in;
      pend_time_ff  <= pend_time_in;
      pend_rep_ff   <= pend_rep_in;
      pend_live_ff  <= pend_live_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_rep_ff    <= rsp_rep_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_fired_slot   = rsp_slot_ff;
   assign rsp_fire_time    = rsp_time_ff;
   assign rsp_will_repeat  = rsp_rep_ff;
   assign rsp_active_count = rsp_count_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

/* rtl/core/rtq_checker.sv */
// ----------------------------------------------------------------------------
// rtq_checker: port-level checks for the timer queue
// Watches the command and result ports over time.
// ----------------------------------------------------------------------------
module rtq_checker
   import rtq_pkg::*;
#(
   parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input logic [1:0]            rsp_status,
   input logic [3:0]            rsp_fired_slot,
   input logic [TIME_WIDTH-1:0] rsp_fire_time,
   input logic                  rsp_last
);

   // Every accepted command either answers at once or starts a tick.
   a_answer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted command neither answered nor started work");

   // The final word of a command leaves the block ready.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("final word shown while still busy");

   // More words follow a word that is not final.
   a_more: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("non-final word with the block idle");

   // A nothing-due word carries no slot and no time, and is final.
   a_none: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_NONE_DUE)) |->
         ((rsp_fired_slot == 4'd0) && (rsp_fire_time == '0) && rsp_last))
      else $error("malformed nothing-due word");

endmodule

bind repeating_timer_event_queue_top rtq_checker #(
   .TIME_WIDTH (TIME_WIDTH)
) u_rtq_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_fired_slot (rsp_fired_slot),
   .rsp_fire_time  (rsp_fire_time),
   .rsp_last       (rsp_last)
);
